FILE: hw/rtl/kuct_pkg.sv
// ---------------------------------------------------------------------------
// Keyed usage counter table package
// Shared request, response and chain token types, status and call codes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kuct_pkg;

	localparam int unsigned TABLE_ENTRIES_DEFAULT = 32;
	localparam logic [3:0]  DATA_SERVICE_RESET    = 4'd4;

	localparam logic [0:0] ACT_UPDATE = 1'b0;
	localparam logic [0:0] ACT_QUERY  = 1'b1;

	localparam logic [3:0] CT_VOICE_OUT = 4'd0;
	localparam logic [3:0] CT_VOICE_IN  = 4'd1;
	localparam logic [3:0] CT_MSG_OUT   = 4'd2;
	localparam logic [3:0] CT_MSG_IN    = 4'd3;

	localparam logic [2:0] ST_UPDATED   = 3'd0;
	localparam logic [2:0] ST_INSERTED  = 3'd1;
	localparam logic [2:0] ST_SKIPPED   = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_FOUND     = 3'd4;
	localparam logic [2:0] ST_NOT_FOUND = 3'd5;

	typedef struct packed {
		logic [0:0]  action;
		logic [31:0] own_key;
		logic [31:0] partner_key;
		logic [3:0]  call_type;
		logic [31:0] duration;
	} kuct_req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] voice_out_total;
		logic [31:0] voice_in_total;
		logic [31:0] message_out_count;
		logic [31:0] message_in_count;
	} kuct_rsp_t;

	// One request as it travels down the row of cells.
	typedef struct packed {
		logic        active;
		logic        query;
		logic        done;
		logic [2:0]  status;
		logic [31:0] key;
		logic [3:0]  call_type;
		logic [31:0] duration;
		logic [31:0] vo;
		logic [31:0] vi;
		logic [31:0] mo;
		logic [31:0] mi;
	} kuct_tok_t;

endpackage

`default_nettype wire

FILE: hw/rtl/kuct_cell.sv
// ---------------------------------------------------------------------------
// Keyed usage counter table cell
// Holds one table entry and passes the request token to its neighbor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kuct_cell
	import kuct_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      adv,
	input  wire kuct_tok_t tok_in,
	output kuct_tok_t      tok_out
);

	logic        valid_q;
	logic [31:0] key_q;
	logic [31:0] vo_q;
	logic [31:0] vi_q;
	logic [31:0] mo_q;
	logic [31:0] mi_q;
	kuct_tok_t   tok_q;

	logic        hit;
	logic        claim;
	logic [31:0] base_vo, base_vi, base_mo, base_mi;
	logic [31:0] nv_vo, nv_vi, nv_mo, nv_mi;
	kuct_tok_t   tok_nx;

	assign hit   = valid_q && (key_q == tok_in.key);
	assign claim = tok_in.active && !tok_in.done && (hit || !valid_q);

	always_comb begin
		base_vo = hit ? vo_q : 32'd0;
		base_vi = hit ? vi_q : 32'd0;
		base_mo = hit ? mo_q : 32'd0;
		base_mi = hit ? mi_q : 32'd0;
		nv_vo   = base_vo;
		nv_vi   = base_vi;
		nv_mo   = base_mo;
		nv_mi   = base_mi;
		case (tok_in.call_type)
			CT_VOICE_OUT: nv_vo = base_vo + tok_in.duration;
			CT_VOICE_IN:  nv_vi = base_vi + tok_in.duration;
			CT_MSG_OUT:   nv_mo = base_mo + 32'd1;
			CT_MSG_IN:    nv_mi = base_mi + 32'd1;
			default: begin
			end
		endcase

		tok_nx = tok_in;
		if (claim) begin
			tok_nx.done = 1'b1;
			if (tok_in.query) begin
				tok_nx.status = hit ? ST_FOUND : ST_NOT_FOUND;
				tok_nx.vo     = base_vo;
				tok_nx.vi     = base_vi;
				tok_nx.mo     = base_mo;
				tok_nx.mi     = base_mi;
			end else begin
				tok_nx.status = hit ? ST_UPDATED : ST_INSERTED;
				tok_nx.vo     = nv_vo;
				tok_nx.vi     = nv_vi;
				tok_nx.mo     = nv_mo;
				tok_nx.mi     = nv_mi;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q   <= '0;
		end else if (adv) begin
			tok_q <= tok_nx;
			if (claim && !tok_in.query) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && claim && !tok_in.query) begin
			key_q <= tok_in.key;
			vo_q  <= nv_vo;
			vi_q  <= nv_vi;
			mo_q  <= nv_mo;
			mi_q  <= nv_mi;
		end
	end

	assign tok_out = tok_q;

endmodule

`default_nettype wire

FILE: hw/rtl/keyed_usage_counter_table.sv
// A request walks the row of entry cells one cell per cycle while the row is not
// stalled, and the response register takes it at the end of the row; only one request
// is in the row at a time, so a new one is taken only once the last has left it.
// A waiting response does not block the next request; the row stalls only when a
// request reaches its end while the response register is still full.
// Reset clears all entry valid bits and sets the data service code to 4.
// ---------------------------------------------------------------------------
// Keyed usage counter table
// Per-key usage counters kept in a row of cells, updated or queried by request.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module keyed_usage_counter_table
	import kuct_pkg::*;
#(
	parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [3:0] cfg_data,
	input  wire logic       req_valid,
	output logic            req_ready,
	input  wire kuct_req_t  req,
	output logic            rsp_valid,
	input  wire logic       rsp_ready,
	output kuct_rsp_t       rsp
);

	// Entries are never removed, so valid entries always form a prefix of the
	// row. A request therefore resolves at the first cell that either holds its
	// key or is still empty; an empty cell is exactly the lowest free slot.

	logic [3:0] code_q;
	logic       busy_q;
	logic       rsp_valid_q;
	kuct_rsp_t  rsp_q;

	kuct_tok_t  tok [TABLE_ENTRIES + 1];
	kuct_tok_t  tok_head;
	kuct_tok_t  last;
	logic       adv;
	logic       accept;
	logic       skip;

	// Configuration is taken at any time; the user must write it only while idle, which the block does not enforce.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q <= DATA_SERVICE_RESET;
		end else if (cfg_valid) begin
			code_q <= cfg_data;
		end
	end

	// The whole row, including entry writes, holds still while the request at
	// its end cannot move into a full response register.
	assign last      = tok[TABLE_ENTRIES];
	assign adv       = !(last.active && rsp_valid_q && !rsp_ready);
	assign req_ready = !busy_q;
	assign accept    = req_valid && req_ready;

	// An update whose keys match, or that carries the data service code, is
	// resolved before it enters the row and passes through untouched.
	assign skip = (req.action == ACT_UPDATE) &&
		((req.own_key == req.partner_key) || (req.call_type == code_q));

	always_comb begin
		tok_head           = '0;
		tok_head.active    = accept;
		tok_head.query     = (req.action == ACT_QUERY);
		tok_head.done      = skip;
		tok_head.status    = ST_SKIPPED;
		tok_head.key       = req.partner_key;
		tok_head.call_type = req.call_type;
		tok_head.duration  = req.duration;
	end

	assign tok[0] = tok_head;

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		kuct_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.tok_in  (tok[i]),
			.tok_out (tok[i + 1])
		);
	end

	// Busy from acceptance until the request leaves the row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (adv && last.active) begin
				busy_q <= 1'b0;
			end
			if (adv && last.active) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// A request still unresolved at the end of the row found no key and no free
	// cell: a query reports not found, an update reports a full table. Its
	// counters are still the zeros it entered with.
	always_ff @(posedge clk) begin
		if (adv && last.active) begin
			rsp_q.status            <= last.done ? last.status :
				(last.query ? ST_NOT_FOUND : ST_FULL);
			rsp_q.voice_out_total   <= last.vo;
			rsp_q.voice_in_total    <= last.vi;
			rsp_q.message_out_count <= last.mo;
			rsp_q.message_in_count  <= last.mi;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

FILE: tb/sv/kuct_tb_pkg.sv
// ---------------------------------------------------------------------------
// Keyed usage counter table checker
// Shadow copy of the key table that predicts and checks every response.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package kuct_tb_pkg;

	import kuct_pkg::*;

	localparam int unsigned SLOTS = TABLE_ENTRIES_DEFAULT;

	class usage_ledger;
		logic [3:0]  service_code;
		bit          slot_used [SLOTS];
		logic [31:0] slot_key  [SLOTS];
		logic [31:0] out_time  [SLOTS];
		logic [31:0] in_time   [SLOTS];
		logic [31:0] out_msgs  [SLOTS];
		logic [31:0] in_msgs   [SLOTS];
		kuct_rsp_t   awaited_totals [$];
		int unsigned mismatches;

		function new();
			service_code = DATA_SERVICE_RESET;
			foreach (slot_used[i]) slot_used[i] = 1'b0;
			mismatches = 0;
		endfunction

		function void set_service_code(logic [3:0] code);
			service_code = code;
		endfunction

		function int unsigned outstanding();
			return awaited_totals.size();
		endfunction

		// Lowest-indexed live slot holding the key, or -1.
		function int find_key(logic [31:0] key);
			for (int i = 0; i < SLOTS; i++) begin
				if (slot_used[i] && slot_key[i] == key) return i;
			end
			return -1;
		endfunction

		function kuct_rsp_t totals_of(int slot, logic [2:0] status);
			kuct_rsp_t res;
			res = '0;
			res.status = status;
			if (slot >= 0) begin
				res.voice_out_total   = out_time[slot];
				res.voice_in_total    = in_time[slot];
				res.message_out_count = out_msgs[slot];
				res.message_in_count  = in_msgs[slot];
			end
			return res;
		endfunction

		function kuct_rsp_t apply_record(kuct_req_t r);
			int         spot;
			logic [2:0] status;
			spot = find_key(r.partner_key);
			if (r.action == ACT_QUERY) begin
				return totals_of(spot, (spot < 0) ? ST_NOT_FOUND : ST_FOUND);
			end
			if (r.own_key == r.partner_key || r.call_type == service_code) begin
				return totals_of(-1, ST_SKIPPED);
			end
			if (spot >= 0) begin
				status = ST_UPDATED;
			end else begin
				for (int i = SLOTS - 1; i >= 0; i--) begin
					if (!slot_used[i]) spot = i;
				end
				if (spot < 0) begin
					return totals_of(-1, ST_FULL);
				end
				slot_used[spot] = 1'b1;
				slot_key[spot]  = r.partner_key;
				out_time[spot]  = '0;
				in_time[spot]   = '0;
				out_msgs[spot]  = '0;
				in_msgs[spot]   = '0;
				status = ST_INSERTED;
			end
			case (r.call_type)
				CT_VOICE_OUT: out_time[spot] += r.duration;
				CT_VOICE_IN:  in_time[spot]  += r.duration;
				CT_MSG_OUT:   out_msgs[spot] += 32'd1;
				CT_MSG_IN:    in_msgs[spot]  += 32'd1;
				default: ;
			endcase
			return totals_of(spot, status);
		endfunction

		function void note_request(kuct_req_t r);
			awaited_totals.push_back(apply_record(r));
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s mismatch: expected 0x%08h, actual 0x%08h", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_response(kuct_rsp_t got);
			kuct_rsp_t want;
			if (awaited_totals.size() == 0) begin
				$error("response with no request outstanding: %p", got);
				mismatches++;
				return;
			end
			want = awaited_totals.pop_front();
			compare_field("status", {29'd0, want.status}, {29'd0, got.status});
			compare_field("voice_out_total", want.voice_out_total, got.voice_out_total);
			compare_field("voice_in_total", want.voice_in_total, got.voice_in_total);
			compare_field("message_out_count", want.message_out_count,
				got.message_out_count);
			compare_field("message_in_count", want.message_in_count, got.message_in_count);
		endfunction
	endclass

endpackage

FILE: tb/sv/tb.sv
// ---------------------------------------------------------------------------
// Keyed usage counter table testbench
// Directed and random update and query requests under random stalls on both
// channels, with several data service codes; every response is checked
// against a shadow table kept by the checker class.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	import kuct_pkg::*;
	import kuct_tb_pkg::*;

	localparam int unsigned HALF_PERIOD = 5;
	localparam int unsigned CYCLE_LIMIT = 600_000;
	localparam int unsigned POOL_SIZE   = 64;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [3:0]  cfg_data  = '0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	kuct_req_t   req       = '0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	kuct_rsp_t   rsp;

	usage_ledger ledger;
	logic [31:0] key_pool [POOL_SIZE];
	int unsigned cycle_count = 0;
	int unsigned ready_left  = 0;

	keyed_usage_counter_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#(HALF_PERIOD) clk = 1'b1;
		#(HALF_PERIOD) clk = 1'b0;
	end

	// Hard stop in case a request or response never completes its handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// The receiver alternates long ready stretches with shorter stalls. Some stall
	// stretches are skipped, so runs of many responses see no back pressure.
	always @(posedge clk) begin
		if (ready_left == 0) begin
			if (rsp_ready && $urandom_range(9) < 7) begin
				rsp_ready  <= 1'b0;
				ready_left <= $urandom_range(25, 1);
			end else begin
				rsp_ready  <= 1'b1;
				ready_left <= $urandom_range(60, 1);
			end
		end else begin
			ready_left <= ready_left - 1;
		end
	end

	// Both handshakes are sampled here with the values held before the edge. A
	// response is always older than any request accepted at the same edge, so it
	// is checked first.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready) ledger.check_response(rsp);
			if (req_valid && req_ready) ledger.note_request(req);
		end
	end

	function automatic kuct_req_t make_record(logic [0:0] action, logic [31:0] own,
		logic [31:0] partner, logic [3:0] ctype, logic [31:0] dur);
		kuct_req_t r;
		r.action      = action;
		r.own_key     = own;
		r.partner_key = partner;
		r.call_type   = ctype;
		r.duration    = dur;
		return r;
	endfunction

	// Updates draw their partner key from the first span entries of the pool, so
	// the span decides how close the table gets to full. Queries sometimes ask for
	// a random key, which is almost always absent.
	function automatic kuct_req_t random_record(int unsigned span);
		kuct_req_t r;
		r.action      = ($urandom_range(99) < 25) ? ACT_QUERY : ACT_UPDATE;
		r.partner_key = key_pool[$urandom_range(span - 1)];
		if (r.action == ACT_QUERY && $urandom_range(4) == 0) r.partner_key = $urandom();
		r.own_key     = ($urandom_range(99) < 6) ? r.partner_key : $urandom();
		r.call_type   = ($urandom_range(99) < 75) ? 4'($urandom_range(3))
			: 4'($urandom_range(15));
		case ($urandom_range(3))
			0: r.duration = $urandom_range(1000);
			1: r.duration = $urandom();
			2: r.duration = 32'hFFFF_FFFF - $urandom_range(15);
			default: r.duration = 32'h8000_0000 | $urandom();
		endcase
		return r;
	endfunction

	// Presents one request and returns at the edge where it is accepted. Valid is
	// left high so that a following request can go out back to back.
	task automatic send_req(input kuct_req_t item);
		req       <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
	endtask

	// The first edge lets the monitor note a request accepted at the edge this
	// task was entered on.
	task automatic wait_drained();
		@(posedge clk);
		while (ledger.outstanding() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_service_code(input logic [3:0] code);
		cfg_data  <= code;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		ledger.set_service_code(code);
	endtask

	// Requests go out in bursts of random length; valid drops only when a gap
	// follows, so it is never lowered and raised in the same step.
	task automatic run_random(input int unsigned count, input int unsigned span);
		int unsigned left;
		int unsigned burst;
		int unsigned gap;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(16, 1);
			if (burst > left) burst = left;
			repeat (burst) send_req(random_record(span));
			left -= burst;
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		req_valid <= 1'b0;
	endtask

	// The code is only changed once every response of the previous phase is in.
	task automatic run_phase(input logic [3:0] code, input int unsigned count,
		input int unsigned span);
		wait_drained();
		write_service_code(code);
		@(posedge clk);
		run_random(count, span);
	endtask

	initial begin
		ledger = new();
		key_pool[0] = 32'h0000_0000;
		key_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests under the reset data service code: empty lookup,
		// both skip reasons, inserts at the key extremes, wrap of both time sums,
		// both message counters, a type that counts nothing, and queries whose
		// unused fields hold junk or equal keys.
		send_req(make_record(ACT_QUERY, 32'h0, 32'h0, CT_VOICE_OUT, 32'h0));
		send_req(make_record(ACT_UPDATE, 32'd5, 32'd5, CT_VOICE_OUT, 32'd10));
		send_req(make_record(ACT_UPDATE, 32'd1, 32'h0, DATA_SERVICE_RESET, 32'd10));
		send_req(make_record(ACT_UPDATE, 32'd1, 32'h0, CT_VOICE_OUT, 32'hFFFF_FFFF));
		send_req(make_record(ACT_UPDATE, 32'hFFFF_FFFF, 32'h0, CT_VOICE_OUT, 32'd1));
		send_req(make_record(ACT_UPDATE, 32'h0, 32'hFFFF_FFFF, CT_VOICE_IN, 32'hFFFF_FFFF));
		send_req(make_record(ACT_UPDATE, 32'h0, 32'hFFFF_FFFF, CT_VOICE_IN, 32'hFFFF_FFFF));
		send_req(make_record(ACT_UPDATE, 32'd2, 32'hFFFF_FFFF, CT_MSG_OUT, 32'd7));
		send_req(make_record(ACT_UPDATE, 32'd3, 32'hFFFF_FFFF, CT_MSG_IN, 32'd7));
		send_req(make_record(ACT_UPDATE, 32'd7, 32'h1234_5678, 4'd15, 32'd99));
		send_req(make_record(ACT_UPDATE, 32'd7, 32'h0, 4'd9, 32'd99));
		send_req(make_record(ACT_QUERY, 32'h0, 32'h0, CT_VOICE_OUT, 32'h0));
		send_req(make_record(ACT_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15,
			32'hFFFF_FFFF));
		send_req(make_record(ACT_QUERY, 32'd1, 32'h1234_5678, CT_MSG_IN, 32'd3));
		send_req(make_record(ACT_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, CT_MSG_IN, 32'd0));
		send_req(make_record(ACT_UPDATE, 32'h0, 32'h0, DATA_SERVICE_RESET, 32'd0));
		send_req(make_record(ACT_UPDATE, 32'hAAAA_AAAA, 32'h5555_5555, CT_MSG_OUT, 32'd0));
		send_req(make_record(ACT_QUERY, 32'hAAAA_AAAA, 32'h5555_5555, CT_VOICE_IN, 32'd0));
		req_valid <= 1'b0;

		// Random phases: the key span grows until the table fills and new keys
		// are dropped, while the data service code moves through its extremes.
		run_phase(4'd0, 340, 12);
		run_phase(4'd15, 340, 20);
		run_phase(4'($urandom_range(15)), 300, 28);
		run_phase(DATA_SERVICE_RESET, 340, 44);
		run_phase(4'($urandom_range(15)), 340, POOL_SIZE);

		// Let any stray response show up before the verdict.
		wait_drained();
		repeat (TABLE_ENTRIES_DEFAULT + 8) @(posedge clk);
		if (ledger.mismatches == 0 && ledger.outstanding() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

FILE: keyed_usage_counter_table.f
hw/rtl/kuct_pkg.sv
hw/rtl/kuct_cell.sv
hw/rtl/keyed_usage_counter_table.sv
tb/sv/kuct_tb_pkg.sv
tb/sv/tb.sv
